// ----- sv/baro_pkg.sv -----
package baro_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 3'd3;

    // arithmetic constants of the compensation
    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        P_FULL      = 21'd1048576;
    localparam logic [63:0]        P_SCALE     = 64'd3125;
    localparam logic [63:0]        A_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic signed [24:0] TC_MIN      = -25'sd16777216;
    localparam logic signed [24:0] TC_MAX      = 25'sd16777215;
    // floor(x / 100) = (x * HPA_RECIP) >> HPA_SHIFT for any 24-bit x
    localparam logic [24:0]        HPA_RECIP   = 25'd21474837;
    localparam int                 HPA_SHIFT   = 31;

    // pipeline depth
    localparam int FRONT_STAGES = 10;
    localparam int DIV_STAGES   = 64;
    localparam int BACK_STAGES  = 6;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    // one stage of the restoring divider
    typedef struct packed {
        logic [63:0]        rem;
        logic [63:0]        quo;
        logic [63:0]        dvs;
        logic               neg;
        logic               dz;
        logic signed [24:0] tc;
    } t_div_stage;

endpackage

// ----- sv/baro_temp_pressure_compensation_core.sv -----
// Barometric temperature and pressure compensation, fully pipelined.
// Input channel: raise i_start with a raw temperature and raw pressure
// sample pair; the item is taken at a clock edge where o_busy is low.
// o_busy is only high during and just after reset, so a new item can be
// taken on every clock cycle.
// Result channel: o_done pulses for one cycle with the compensated
// temperature, pressure in Q24.8 Pa, whole hPa and the divide-by-zero flag.
// The receiver cannot stall; results appear in the order items were taken.
// Pipeline: the 64-stage one-bit-per-stage restoring divider sits between ten
// stages ahead of it (temperature and divisor/dividend products) and six
// after it (quotient sign, square-term correction, final pressure and hPa
// conversion). Throughput: one item per cycle.
// Calibration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while no item is in flight, which the block does
// not enforce. Reset clears calibration and all valid bits, so items in
// flight at reset are dropped.
module baro_temp_pressure_compensation_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [19:0]                   i_raw_temperature,
    input  logic [19:0]                   i_raw_pressure,
    input  logic                          i_cfg_we,
    input  logic [baro_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output logic                          o_done,
    output logic signed [24:0]            o_temperature_centi,
    output logic [31:0]                   o_pressure_pa_q8,
    output logic [17:0]                   o_pressure_hpa,
    output logic                          o_divide_by_zero
);
    import baro_pkg::*;

    // calibration registers
    logic [47:0]        r_temp_cal;
    logic [63:0]        r_press_lo;
    logic [63:0]        r_press_hi;
    logic signed [15:0] r_press_last;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8;

    logic r_ready;
    logic w_acc;

    // front stage registers
    logic [FRONT_STAGES:1] r_fv;
    logic [19:0]        r_raw_t;
    logic [19:0]        r_rp [1:7];
    logic signed [31:0] r_v1_2, r_v1_3;
    logic [31:0]        r_dd;
    logic [31:0]        r_m3;
    logic signed [24:0] r_tc [4:9];
    logic signed [32:0] r_a;
    logic [63:0]        r_aa;
    logic signed [48:0] r_ap5_5, r_ap2_5, r_ap5_6, r_ap2_6;
    logic [63:0]        r_bp6, r_t3p;
    logic [63:0]        r_b, r_a2;
    logic [63:0]        r_a3p, r_num0;
    logic [63:0]        r_den, r_num;
    t_div_stage         r_d0;

    // divider pipeline
    t_div_stage         r_div [1:DIV_STAGES];
    logic [DIV_STAGES:1] r_dv;

    // back stage registers
    logic [BACK_STAGES-1:1] r_bv;
    logic [63:0]        r_p1, r_p2, r_p3, r_p4;
    logic [63:0]        r_ps, r_m9, r_c2_2, r_c2_3, r_c2_4;
    logic [63:0]        r_ll;
    logic [31:0]        r_lh, r_hl;
    logic [63:0]        r_c1;
    logic [31:0]        r_pq;
    logic signed [24:0] r_btc [1:BACK_STAGES-1];
    logic               r_bdz [1:BACK_STAGES-1];

    // output registers
    logic               r_done;
    logic signed [24:0] r_tco;
    logic [31:0]        r_pao;
    logic [17:0]        r_hpao;
    logic               r_dzo;

    // combinational terms
    logic [31:0]        w_d1, w_d2, w_m1;
    logic signed [31:0] w_fine;
    logic signed [35:0] w_fx, w_t;
    logic signed [24:0] w_tc;
    logic signed [65:0] w_aa;
    logic [20:0]        w_pn;
    logic [63:0]        w_q, w_pf;
    logic [48:0]        w_hpa;

    // calibration word slices
    assign t1 = r_temp_cal[15:0];
    assign t2 = r_temp_cal[31:16];
    assign t3 = r_temp_cal[47:32];
    assign p1 = r_press_lo[15:0];
    assign p2 = r_press_lo[31:16];
    assign p3 = r_press_lo[47:32];
    assign p4 = r_press_lo[63:48];
    assign p5 = r_press_hi[15:0];
    assign p6 = r_press_hi[31:16];
    assign p7 = r_press_hi[47:32];
    assign p8 = r_press_hi[63:48];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= '0;
            r_press_lo   <= '0;
            r_press_hi   <= '0;
            r_press_last <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_CAL:   r_temp_cal   <= i_cfg_data[47:0];
                CFG_PRESS_LO:   r_press_lo   <= i_cfg_data;
                CFG_PRESS_HI:   r_press_hi   <= i_cfg_data;
                CFG_PRESS_LAST: r_press_last <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ready after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_busy = ~r_ready;
    assign w_acc  = i_start & r_ready;

    // front valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            r_fv <= {r_fv[FRONT_STAGES-1:1], w_acc};
        end
    end

    // temperature differences and first products
    assign w_d1 = 32'(r_raw_t >> 3) - {15'b0, t1, 1'b0};
    assign w_d2 = 32'(r_raw_t >> 4) - {16'b0, t1};
    assign w_m1 = w_d1 * 32'(t2);

    // fine temperature and centi-degree result
    assign w_fine = r_v1_3 + ($signed(r_m3) >>> 14);
    assign w_fx   = 36'(w_fine);
    assign w_t    = (w_fx * 36'sd5 + 36'sd128) >>> 8;
    always_comb begin
        if (w_t < 36'(TC_MIN)) begin
            w_tc = TC_MIN;
        end else if (w_t > 36'(TC_MAX)) begin
            w_tc = TC_MAX;
        end else begin
            w_tc = w_t[24:0];
        end
    end

    assign w_aa = r_a * r_a;
    assign w_pn = P_FULL - {1'b0, r_rp[7]};

    // front pipeline stages
    always_ff @(posedge i_clk) begin
        // stage 1: capture item
        r_raw_t <= i_raw_temperature;
        r_rp[1] <= i_raw_pressure;
        for (int i = 2; i <= 7; i++) begin
            r_rp[i] <= r_rp[i-1];
        end
        // stage 2: first temperature products
        r_v1_2 <= $signed(w_m1) >>> 11;
        r_dd   <= w_d2 * w_d2;
        // stage 3: square term times T3
        r_v1_3 <= r_v1_2;
        r_m3   <= 32'($signed(r_dd) >>> 12) * 32'(t3);
        // stage 4: fine temperature
        r_tc[4] <= w_tc;
        r_a     <= 33'(w_fine) - FINE_OFFSET;
        for (int i = 5; i <= 9; i++) begin
            r_tc[i] <= r_tc[i-1];
        end
        // stage 5: products of the fine offset
        r_aa    <= w_aa[63:0];
        r_ap5_5 <= r_a * p5;
        r_ap2_5 <= r_a * p2;
        // stage 6: square times P6 and P3
        r_bp6   <= 64'($signed(r_aa) * p6);
        r_t3p   <= 64'($signed(r_aa) * p3);
        r_ap5_6 <= r_ap5_5;
        r_ap2_6 <= r_ap2_5;
        // stage 7: sums
        r_b  <= r_bp6 + (64'(r_ap5_6) << 17) + (64'(p4) << 35);
        r_a2 <= 64'($signed(r_t3p) >>> 8) + (64'(r_ap2_6) << 12);
        // stage 8: divisor product and dividend base
        r_a3p  <= (A_BIAS + r_a2) * {48'b0, p1};
        r_num0 <= ({43'b0, w_pn} << 31) - r_b;
        // stage 9: divisor and dividend
        r_den <= 64'($signed(r_a3p) >>> 33);
        r_num <= r_num0 * P_SCALE;
        // stage 10: magnitudes for the divider
        r_d0.rem  <= '0;
        r_d0.quo  <= r_num[63] ? (64'd0 - r_num) : r_num;
        r_d0.dvs  <= r_den[63] ? (64'd0 - r_den) : r_den;
        r_d0.neg  <= r_num[63] ^ r_den[63];
        r_d0.dz   <= (r_den == 64'd0);
        r_d0.tc   <= r_tc[9];
    end

    // divider: one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= {r_dv[DIV_STAGES-1:1], r_fv[FRONT_STAGES]};
        end
    end

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        t_div_stage w_in;
        logic [63:0] w_sh;
        logic        w_ge;
        if (g == 1) begin : g_first
            assign w_in = r_d0;
        end else begin : g_rest
            assign w_in = r_div[g-1];
        end
        assign w_sh = {w_in.rem[62:0], w_in.quo[63]};
        assign w_ge = (w_sh >= w_in.dvs);
        always_ff @(posedge i_clk) begin
            r_div[g].rem <= w_ge ? (w_sh - w_in.dvs) : w_sh;
            r_div[g].quo <= {w_in.quo[62:0], w_ge};
            r_div[g].dvs <= w_in.dvs;
            r_div[g].neg <= w_in.neg;
            r_div[g].dz  <= w_in.dz;
            r_div[g].tc  <= w_in.tc;
        end
    end

    // back valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= '0;
            r_done <= 1'b0;
        end else begin
            r_bv   <= {r_bv[BACK_STAGES-2:1], r_dv[DIV_STAGES]};
            r_done <= r_bv[BACK_STAGES-1];
        end
    end

    assign w_q  = r_div[DIV_STAGES].quo;
    assign w_pf = 64'(($signed(r_p4) + ($signed(r_c1) >>> 25)
                  + ($signed(r_c2_4) >>> 19)) >>> 8) + (64'(p7) << 4);
    assign w_hpa = r_pq[31:8] * HPA_RECIP;

    // back pipeline stages
    always_ff @(posedge i_clk) begin
        r_btc[1] <= r_div[DIV_STAGES].tc;
        r_bdz[1] <= r_div[DIV_STAGES].dz;
        for (int i = 2; i <= BACK_STAGES-1; i++) begin
            r_btc[i] <= r_btc[i-1];
            r_bdz[i] <= r_bdz[i-1];
        end
        // signed quotient
        r_p1 <= r_div[DIV_STAGES].neg ? (64'd0 - w_q) : w_q;
        // scaled pressure, P9 and P8 products
        r_p2   <= r_p1;
        r_ps   <= 64'($signed(r_p1) >>> 13);
        r_m9   <= 64'($signed(64'($signed(r_p1) >>> 13)) * r_press_last);
        r_c2_2 <= 64'($signed(r_p1) * p8);
        // partial products of the square term
        r_p3   <= r_p2;
        r_c2_3 <= r_c2_2;
        r_ll   <= r_m9[31:0] * r_ps[31:0];
        r_lh   <= r_m9[31:0] * r_ps[63:32];
        r_hl   <= r_m9[63:32] * r_ps[31:0];
        // square term
        r_p4   <= r_p3;
        r_c2_4 <= r_c2_3;
        r_c1   <= r_ll + {r_lh + r_hl, 32'b0};
        // final pressure
        r_pq   <= w_pf[31:0];
        // output register
        r_tco  <= r_btc[BACK_STAGES-1];
        r_dzo  <= r_bdz[BACK_STAGES-1];
        r_pao  <= r_bdz[BACK_STAGES-1] ? 32'd0 : r_pq;
        r_hpao <= r_bdz[BACK_STAGES-1] ? 18'd0 : w_hpa[HPA_SHIFT +: 18];
    end

    assign o_done              = r_done;
    assign o_temperature_centi = r_tco;
    assign o_pressure_pa_q8    = r_pao;
    assign o_pressure_hpa      = r_hpao;
    assign o_divide_by_zero    = r_dzo;

endmodule

// ----- sv/baro_chk.sv -----
module baro_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input logic                           o_busy,
    input logic                           o_done,
    input logic [31:0]                    o_pressure_pa_q8,
    input logic [17:0]                    o_pressure_hpa,
    input logic                           o_divide_by_zero
);
    import baro_pkg::*;

    logic w_acc;
    assign w_acc = i_start & ~o_busy;

    // every item gives its result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LATENCY o_done)
        else $error("result missing after latency");

    // no result without an item taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LATENCY))
        else $error("result without item");

    // zero divisor forces both pressures to zero
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |->
            (o_pressure_pa_q8 == 32'd0 && o_pressure_hpa == 18'd0))
        else $error("pressure not cleared on zero divisor");

    // hPa agrees with the Q24.8 pressure
    a_hpa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_divide_by_zero) |->
            (({22'b0, o_pressure_hpa} * 40'd25600 <= {8'b0, o_pressure_pa_q8}) &&
             ({8'b0, o_pressure_pa_q8} < ({22'b0, o_pressure_hpa} + 40'd1) * 40'd25600)))
        else $error("hPa mismatch");

endmodule

bind baro_temp_pressure_compensation_core baro_chk u_baro_chk (.*);

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import baro_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    // an index that names no register
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd5;

    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
    } t_raw_pair;

    typedef struct {
        logic signed [24:0] temp_centi;
        logic [31:0]        pa_q8;
        logic [17:0]        hpa;
        logic               dz;
    } t_comp_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [19:0]          i_raw_temperature;
    logic [19:0]          i_raw_pressure;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;
    logic                 o_done;
    logic signed [24:0]   o_temperature_centi;
    logic [31:0]          o_pressure_pa_q8;
    logic [17:0]          o_pressure_hpa;
    logic                 o_divide_by_zero;

    baro_temp_pressure_compensation_core dut (.*);

    // calibration as the block should hold it
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_p9;

    t_raw_pair    pairs_pending[$];
    t_comp_result results_due[$];
    logic         taken;
    logic         calm;
    int           mismatches;
    int           quiet_cycles;

    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    // signed truncating division, most negative by -1 wraps
    function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? 64'd0 - n : n;
        md = d[63] ? 64'd0 - d : d;
        q  = mn / md;
        return (n[63] != d[63]) ? 64'd0 - q : q;
    endfunction

    function automatic t_comp_result compensate(input t_raw_pair pr);
        t_comp_result r;
        logic [31:0] adc_t, t1, t2, t3, d1, v1, d2, sq, v2, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] t, a, b, m, c, num, p, ps, c1, c2;
        adc_t = {12'd0, pr.raw_t};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_press_lo[15:0]};
        p2 = sext16(cal_press_lo[31:16]);
        p3 = sext16(cal_press_lo[47:32]);
        p4 = sext16(cal_press_lo[63:48]);
        p5 = sext16(cal_press_hi[15:0]);
        p6 = sext16(cal_press_hi[31:16]);
        p7 = sext16(cal_press_hi[47:32]);
        p8 = sext16(cal_press_hi[63:48]);
        p9 = sext16(cal_p9);

        // fine temperature, 32-bit wrapping
        d1 = (adc_t >> 3) - (t1 << 1);
        m = {32'd0, d1 * t2};
        v1 = asr32(m[31:0], 11);
        d2 = (adc_t >> 4) - t1;
        sq = asr32(d2 * d2, 12);
        v2 = asr32(sq * t3, 14);
        fine = v1 + v2;

        t = asr64({{32{fine[31]}}, fine} * 64'd5 + 64'd128, 8);
        if ($signed(t) < 64'sd0 - 64'sd16777216)
            r.temp_centi = TC_MIN;
        else if ($signed(t) > 64'sd16777215)
            r.temp_centi = TC_MAX;
        else
            r.temp_centi = t[24:0];

        // pressure, 64-bit wrapping
        a = {{32{fine[31]}}, fine} - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        c = asr64(a * a * p3, 8) + ((a * p2) << 12);
        c = asr64((A_BIAS + c) * p1, 33);
        if (c == 64'd0) begin
            r.pa_q8 = '0;
            r.hpa = '0;
            r.dz = 1'b1;
            return r;
        end
        p = 64'd1048576 - {44'd0, pr.raw_p};
        num = ((p << 31) - b) * 64'd3125;
        p = div_trunc(num, c);
        ps = asr64(p, 13);
        c1 = asr64(p9 * ps * ps, 25);
        c2 = asr64(p8 * p, 19);
        p = asr64(p + c1 + c2, 8) + (p7 << 4);
        r.pa_q8 = p[31:0];
        r.hpa = 18'(r.pa_q8 / 256 / 100);
        r.dz = 1'b0;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // calibration tracking at the write edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_temp <= '0;
            cal_press_lo <= '0;
            cal_press_hi <= '0;
            cal_p9 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_CAL:   cal_temp <= i_cfg_data[47:0];
                CFG_PRESS_LO:   cal_press_lo <= i_cfg_data;
                CFG_PRESS_HI:   cal_press_hi <= i_cfg_data;
                CFG_PRESS_LAST: cal_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item acceptance and prediction
    always @(posedge i_clk) begin
        taken <= 1'b0;
        if (i_rst_n && i_start && !o_busy) begin
            taken <= 1'b1;
            results_due.push_back(compensate(pairs_pending.pop_front()));
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_start <= 1'b0;
        else if (i_start && !taken)
            ;
        else if (pairs_pending.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
            i_start <= 1'b1;
            i_raw_temperature <= pairs_pending[0].raw_t;
            i_raw_pressure <= pairs_pending[0].raw_p;
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_comp_result want;
        if (i_rst_n && o_done) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end else begin
                want = results_due.pop_front();
                if (o_temperature_centi !== want.temp_centi
                        || o_pressure_pa_q8 !== want.pa_q8
                        || o_pressure_hpa !== want.hpa
                        || o_divide_by_zero !== want.dz) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp tc=%0d pa=%h hpa=%0d dz=%b",
                                 want.temp_centi, want.pa_q8, want.hpa, want.dz);
                        $display("          got tc=%0d pa=%h hpa=%0d dz=%b",
                                 o_temperature_centi, o_pressure_pa_q8, o_pressure_hpa,
                                 o_divide_by_zero);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pairs_pending.size() > 0 || results_due.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic add_pair(input logic [19:0] rt, input logic [19:0] rp);
        t_raw_pair pr;
        pr.raw_t = rt;
        pr.raw_p = rp;
        pairs_pending.push_back(pr);
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] w, input int span);
        return w + 16'($urandom_range(2 * span) - span);
    endfunction

    // typical factory calibration, optionally perturbed
    task automatic load_typical(input int span);
        cfg_write(CFG_TEMP_CAL, {16'($urandom), jitter(16'hfc18, span),
                                 jitter(16'd26435, span), jitter(16'd27504, span)});
        cfg_write(CFG_PRESS_LO, {jitter(16'd2855, span), jitter(16'd3024, span),
                                 jitter(16'hd643, span), jitter(16'd36477, span)});
        cfg_write(CFG_PRESS_HI, {jitter(16'hc6f8, span), jitter(16'd15500, span),
                                 jitter(16'hfff9, span), jitter(16'd140, span)});
        cfg_write(CFG_PRESS_LAST, {$urandom, 16'($urandom), jitter(16'd6000, span)});
    endtask

    initial begin
        int ph, k, kind;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // calibration at reset: divisor is zero
        add_pair(20'h00000, 20'h00000);
        add_pair(20'hfffff, 20'hfffff);
        add_pair(20'd519888, 20'd415148);
        wait_idle();

        // typical calibration, field extremes
        load_typical(0);
        cfg_write(CFG_IDX_NONE, {2{$urandom}});
        add_pair(20'd519888, 20'd415148);
        add_pair(20'h00000, 20'h00000);
        add_pair(20'hfffff, 20'hfffff);
        add_pair(20'h00000, 20'hfffff);
        add_pair(20'hfffff, 20'h00000);
        add_pair(20'h55555, 20'haaaaa);
        add_pair(20'haaaaa, 20'h55555);
        add_pair(20'd440000, 20'd300000);
        add_pair(20'd600000, 20'd500000);
        wait_idle();

        // extreme calibrations
        cfg_write(CFG_TEMP_CAL, 64'hffff_ffff_ffff_ffff);
        cfg_write(CFG_PRESS_LO, 64'hffff_ffff_ffff_ffff);
        cfg_write(CFG_PRESS_HI, 64'hffff_ffff_ffff_ffff);
        cfg_write(CFG_PRESS_LAST, 64'hffff_ffff_ffff_ffff);
        add_pair(20'h00000, 20'h00000);
        add_pair(20'hfffff, 20'hfffff);
        add_pair(20'd519888, 20'd415148);
        wait_idle();
        cfg_write(CFG_TEMP_CAL, 64'h0000_8000_7fff_0000);
        cfg_write(CFG_PRESS_LO, 64'h7fff_8000_7fff_ffff);
        cfg_write(CFG_PRESS_HI, 64'h8000_7fff_8000_7fff);
        cfg_write(CFG_PRESS_LAST, 64'h0000_0000_0000_8000);
        add_pair(20'h00000, 20'h00000);
        add_pair(20'hfffff, 20'hfffff);
        add_pair(20'h12345, 20'h6789a);
        wait_idle();

        // random phases
        for (ph = 0; ph < 10; ph++) begin
            kind = $urandom_range(3);
            if (kind == 0) begin
                cfg_write(CFG_TEMP_CAL, {$urandom, $urandom});
                cfg_write(CFG_PRESS_LO, {$urandom, $urandom});
                cfg_write(CFG_PRESS_HI, {$urandom, $urandom});
                cfg_write(CFG_PRESS_LAST, {$urandom, $urandom});
            end else begin
                load_typical(kind == 1 ? 0 : 2000);
            end
            calm = (ph == 4);
            for (k = 0; k < 120; k++) begin
                if ($urandom_range(2) == 0)
                    add_pair(20'($urandom), 20'($urandom));
                else
                    add_pair(20'($urandom_range(600000, 400000)),
                             20'($urandom_range(500000, 200000)));
            end
            wait_idle();
        end

        if (mismatches == 0 && results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
